// ----- rtl/wtsf_pkg.sv -----
// shared constants for the waveform table segment fill block
package wtsf_pkg;
	localparam int TABLE_DEPTH = 8192;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SAMPLE_W    = 12;
	localparam int FRAC_W      = 16;
	localparam int NUM_W       = SAMPLE_W + FRAC_W;
	localparam int ACC_W       = NUM_W + 3;
	localparam int CNT_W       = $clog2(NUM_W);
	localparam int DATA_W      = 32;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
	localparam logic [SAMPLE_W-1:0] MID_SCALE  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_READ = 1'b1;
endpackage

// ----- rtl/waveform_table_segment_fill_core.sv -----
// waveform table with linear segment fill between marked set points
//
// Input stream s_*: one transaction per item. s_tuser is the kind (set point or
// read), s_tdata carries position and sample. Output stream m_*: one transaction
// per item with the read or written sample and the left end of the segment.
// After reset the block sweeps both memories, one entry a cycle (table to
// mid-scale, marks cleared), and takes no item until the sweep is done. A read
// loads its table entry in ST_RDWAIT and returns it from ST_RESULT. A set point
// writes its sample and mark, then scans the mark memory downwards one position
// a cycle for the nearest marked point, reads the left value, derives the slope
// in a restoring divider and writes the ramp one entry a cycle through the
// single table write port.
// Items are handled one at a time; the result sits in an output register, so
// the next item is taken while it waits. If the receiver stalls, a finished
// result waits in the block and no further item is accepted until it is taken.
module waveform_table_segment_fill_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [wtsf_pkg::DATA_W-1:0] s_tdata,  // position, sample_value
	input  logic                        s_tuser,  // kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wtsf_pkg::DATA_W-1:0] m_tdata   // read_value, segment_start
);
	import wtsf_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RDWAIT = 4'd2;
	localparam logic [3:0] ST_SEARCH = 4'd3;
	localparam logic [3:0] ST_LEFT   = 4'd4;
	localparam logic [3:0] ST_LWAIT  = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_DIVEND = 4'd7;
	localparam logic [3:0] ST_FILL   = 4'd8;
	localparam logic [3:0] ST_RESULT = 4'd9;

	logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
	logic                mark_mem [TABLE_DEPTH];

	logic [3:0]          state_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                kind_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [SAMPLE_W-1:0] val_q;
	logic [ADDR_W-1:0]   j_q;
	logic                chk_valid_q;
	logic [ADDR_W-1:0]   chk_addr_q;
	logic [ADDR_W-1:0]   start_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [NUM_W-1:0]    num_q;
	logic [ADDR_W-1:0]   rem_q;
	logic                neg_q;
	logic [ADDR_W:0]     span_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [ACC_W-1:0] slope_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ADDR_W-1:0]   fill_idx_q;
	logic [SAMPLE_W-1:0] res_val_q;
	logic [ADDR_W-1:0]   res_start_q;
	logic                m_tvalid_q;
	logic [DATA_W-1:0]   m_tdata_q;

	logic [SAMPLE_W-1:0] wave_rd_q;
	logic                mark_rd_q;

	logic                wave_we, mark_we, mark_wd;
	logic [ADDR_W-1:0]   wave_wa, wave_ra, mark_wa, mark_ra;
	logic [SAMPLE_W-1:0] wave_wd;

	logic                in_acc;
	logic [ADDR_W-1:0]   in_pos;
	logic [SAMPLE_W-1:0] in_val;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W-1:0] diff_mag;
	logic [ADDR_W:0]     rem_sh;
	logic signed [ACC_W-1:0] acc_rnd;
	logic [ACC_W-FRAC_W-1:0] smp_wide;
	logic [SAMPLE_W-1:0] smp;
	logic signed [ACC_W-1:0] quo;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_pos   = s_tdata[ADDR_W-1:0];
	assign in_val   = s_tdata[ADDR_W +: SAMPLE_W];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign diff     = $signed({1'b0, val_q}) - $signed({1'b0, wave_rd_q});
	assign diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign acc_rnd  = acc_q + ACC_W'(32'sd32768);
	assign smp_wide = acc_rnd[ACC_W-1:FRAC_W];
	assign quo      = ACC_W'(num_q);

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			smp = '0;
		end else if (smp_wide > (ACC_W-FRAC_W)'(SAMPLE_MAX)) begin
			smp = SAMPLE_MAX;
		end else begin
			smp = smp_wide[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		wave_we = 1'b0;
		wave_wa = clr_addr_q;
		wave_wd = MID_SCALE;
		mark_we = 1'b0;
		mark_wa = clr_addr_q;
		mark_wd = 1'b0;
		wave_ra = in_pos;
		mark_ra = j_q;
		unique case (state_q)
			ST_CLEAR: begin
				wave_we = 1'b1;
				mark_we = 1'b1;
			end
			ST_IDLE: begin
				if (in_acc && s_tuser == KIND_SET) begin
					wave_we = 1'b1;
					wave_wa = in_pos;
					wave_wd = in_val;
					mark_we = 1'b1;
					mark_wa = in_pos;
					mark_wd = 1'b1;
				end
			end
			ST_LEFT: wave_ra = start_q;
			ST_FILL: begin
				wave_we = 1'b1;
				wave_wa = fill_idx_q;
				wave_wd = smp;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wave_we) begin
			wave_mem[wave_wa] <= wave_wd;
		end
		wave_rd_q <= wave_mem[wave_ra];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		mark_rd_q <= mark_mem[mark_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			chk_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						kind_q  <= s_tuser;
						pos_q   <= in_pos;
						val_q   <= in_val;
						start_q <= '0;
						if (s_tuser == KIND_READ) begin
							state_q <= ST_RDWAIT;
						end else if (in_pos == '0) begin
							state_q <= ST_RESULT;
						end else begin
							j_q         <= in_pos - 1'b1;
							chk_valid_q <= 1'b0;
							state_q     <= ST_SEARCH;
						end
					end
				end
				ST_RDWAIT: begin
					val_q   <= wave_rd_q;
					state_q <= ST_RESULT;
				end
				ST_SEARCH: begin
					if (chk_valid_q && (mark_rd_q || chk_addr_q == '0)) begin
						start_q     <= mark_rd_q ? chk_addr_q : '0;
						chk_valid_q <= 1'b0;
						state_q     <= ST_LEFT;
					end else begin
						chk_addr_q  <= j_q;
						chk_valid_q <= 1'b1;
						j_q         <= j_q - 1'b1;
					end
				end
				ST_LEFT: begin
					span_q  <= {1'b0, pos_q} - {1'b0, start_q};
					state_q <= ST_LWAIT;
				end
				ST_LWAIT: begin
					left_q  <= wave_rd_q;
					neg_q   <= diff[SAMPLE_W];
					num_q   <= {diff_mag, {FRAC_W{1'b0}}};
					rem_q   <= '0;
					cnt_q   <= CNT_W'(NUM_W - 1);
					state_q <= (span_q < (ADDR_W+1)'(2)) ? ST_RESULT : ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= span_q) begin
						rem_q <= ADDR_W'(rem_sh - span_q);
						num_q <= {num_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[ADDR_W-1:0];
						num_q <= {num_q[NUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					slope_q    <= neg_q ? -quo : quo;
					acc_q      <= $signed(ACC_W'({left_q, {FRAC_W{1'b0}}}))
						+ (neg_q ? -quo : quo);
					fill_idx_q <= start_q + 1'b1;
					state_q    <= ST_FILL;
				end
				ST_FILL: begin
					acc_q      <= acc_q + slope_q;
					fill_idx_q <= fill_idx_q + 1'b1;
					if (fill_idx_q == pos_q - 1'b1) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= DATA_W'({(kind_q == KIND_READ) ? ADDR_W'(0) : start_q, val_q});
		end
	end

	assign res_val_q   = m_tdata_q[SAMPLE_W-1:0];
	assign res_start_q = m_tdata_q[SAMPLE_W +: ADDR_W];

	a_fill_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fill_idx_q > start_q && fill_idx_q < pos_q))
		else $error("fill outside segment");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (span_q >= (ADDR_W+1)'(2) && rem_q < span_q))
		else $error("divider out of range");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!m_tvalid_q && !s_tready))
		else $error("activity during clearing sweep");

	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) && $past(kind_q == KIND_READ) |-> (res_start_q == '0))
		else $error("read result with nonzero segment start");

	a_set_value: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) && $past(kind_q == KIND_SET) |-> (res_val_q == $past(val_q)))
		else $error("set result value mismatch");
endmodule
